// ===== hdl/nfa_pkg.sv =====
// Shared constants, codes and types of the next-fit identifier allocator.
`timescale 1ns / 1ps

package nfa_pkg;

  // Number of identifier slots in the map.
  localparam int unsigned SLOTS = 64;
  // Bits of a slot index.
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // Bits of an identifier on the ports (identifiers run 1..SLOTS).
  localparam int unsigned ID_W  = 7;
  localparam int unsigned ST_W  = 2;

  // Command codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_FREE  = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  // Controls broadcast to every cell of the ring.
  typedef struct packed {
    logic load;     // place the search token at the start slot
    logic advance;  // hand the token to the next cell
    logic grant;    // mark the slot under the token as used
  } cell_ctrl_t;

endpackage

// ===== hdl/nfa_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one request beat.
`timescale 1ns / 1ps

interface nfa_cmd_if;
  import nfa_pkg::*;

  logic            valid;
  logic            ready;
  logic            command;
  logic [ID_W-1:0] release_id;

  modport source (output valid, output command, output release_id, input ready);
  modport sink   (input valid, input command, input release_id, output ready);
endinterface

// ===== hdl/nfa_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result beat.
`timescale 1ns / 1ps

interface nfa_rsp_if;
  import nfa_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] granted_id;
  logic [ST_W-1:0] status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

// ===== hdl/nfa_cell.sv =====
// One slot of the ring: used bit plus search token passed to the neighbor.
`timescale 1ns / 1ps

module nfa_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nfa_pkg::cell_ctrl_t ctrl_i,
  input  logic               load_sel_i,
  input  logic               clr_i,
  input  logic               token_prev_i,
  output logic               token_o,
  output logic               used_o,
  output logic               hit_o
);
  import nfa_pkg::*;

  logic used_q, used_d;
  logic token_q, token_d;

  always_comb begin
    token_d = token_q;
    if (ctrl_i.load) begin
      token_d = load_sel_i;
    end else if (ctrl_i.advance) begin
      token_d = token_prev_i;
    end
  end

  always_comb begin
    used_d = used_q;
    if (ctrl_i.grant && token_q) begin
      used_d = 1'b1;
    end else if (clr_i) begin
      used_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      token_q <= 1'b0;
    end else begin
      used_q  <= used_d;
      token_q <= token_d;
    end
  end

  assign token_o = token_q;
  assign used_o  = used_q;
  assign hit_o   = token_q & ~used_q;

endmodule

// ===== hdl/next_fit_id_allocator.sv =====
// Top level of the next-fit identifier allocator: cell ring, sequencer, result register.
`timescale 1ns / 1ps

// The allocator keeps one used bit per identifier slot in a ring of cells and
// remembers the slot it granted last. A release beat (command 1) is checked and
// answered in the cycle it is accepted: status 2 for an identifier of zero or
// above SLOTS, status 3 for one that is not allocated, otherwise the bit is
// cleared and status 0 returns; granted_id is always zero on a release. An
// allocate beat (command 0) drops a search token into the cell of the last
// granted slot; the token then moves one cell per clock around the ring until
// it sits on a free slot, which is marked used and returned as slot number
// plus one, after passing over at most SLOTS - 1 used slots; with the map
// full the token makes a full lap and status 1 with granted_id 0 is loaded.
// One request is in flight at a time: a new request is accepted only in the
// idle state and only while the result register is empty or its beat leaves
// in that same cycle, and a finished scan holds while the previous result
// still waits.

module next_fit_id_allocator (
  input  logic       clk_i,
  input  logic       rst_ni,
  nfa_cmd_if.sink    cmd_i,
  nfa_rsp_if.source  rsp_o
);
  import nfa_pkg::*;

  // Sequencer.
  state_e state_q, state_d;

  // Scan bookkeeping: last granted slot, slot under the token and number of steps taken.
  logic [IDX_W-1:0] last_q, last_d;
  logic [IDX_W-1:0] probe_q, probe_d;
  logic [IDX_W-1:0] steps_q, steps_d;

  // Result register.
  logic            out_valid_q, out_valid_d;
  logic [ID_W-1:0] out_id_q, out_id_d;
  logic [ST_W-1:0] out_st_q, out_st_d;

  // Ring signals.
  cell_ctrl_t       ctrl;
  logic [SLOTS-1:0] token;
  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] hit;
  logic [SLOTS-1:0] load_sel;
  logic [SLOTS-1:0] clr;

  logic             out_free;
  logic             cmd_take;
  logic             any_hit;
  logic             rid_bad;
  logic [IDX_W-1:0] rid_idx;
  logic             rid_used;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == S_IDLE) && out_free;
  assign cmd_take = cmd_i.valid && cmd_i.ready;
  assign any_hit  = |hit;

  // Release checks: range, then the used bit of the named slot.
  assign rid_bad  = (cmd_i.release_id == '0) || (cmd_i.release_id > ID_W'(SLOTS));
  assign rid_idx  = IDX_W'(cmd_i.release_id - ID_W'(1));
  assign rid_used = used[rid_idx];

  // Build the ring: each cell takes the token from the one below it.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    localparam int unsigned PREV = (i == 0) ? SLOTS - 1 : i - 1;

    assign load_sel[i] = (last_q == IDX_W'(i));
    assign clr[i] = cmd_take && (cmd_i.command == CMD_RELEASE) && !rid_bad
                    && (rid_idx == IDX_W'(i));

    nfa_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .load_sel_i   (load_sel[i]),
      .clr_i        (clr[i]),
      .token_prev_i (token[PREV]),
      .token_o      (token[i]),
      .used_o       (used[i]),
      .hit_o        (hit[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    probe_d     = probe_q;
    steps_d     = steps_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_id_d    = out_id_q;
    out_st_d    = out_st_q;
    ctrl        = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_take) begin
          if (cmd_i.command == CMD_ALLOC) begin
            // Drop the token on the last granted slot and start walking.
            ctrl.load = 1'b1;
            probe_d   = last_q;
            steps_d   = '0;
            state_d   = S_SCAN;
          end else begin
            // Answer a release at once; the cell clears its own bit.
            out_valid_d = 1'b1;
            out_id_d    = '0;
            if (rid_bad) begin
              out_st_d = ST_RANGE;
            end else if (!rid_used) begin
              out_st_d = ST_FREE;
            end else begin
              out_st_d = ST_OK;
            end
          end
        end
      end

      S_SCAN: begin
        if (any_hit) begin
          // Token sits on a free slot: grant it once the result register frees up.
          if (out_free) begin
            ctrl.grant  = 1'b1;
            last_d      = probe_q;
            out_valid_d = 1'b1;
            out_id_d    = ID_W'(probe_q) + ID_W'(1);
            out_st_d    = ST_OK;
            state_d     = S_IDLE;
          end
        end else if (steps_q == IDX_W'(SLOTS - 1)) begin
          // Full lap without a free slot.
          if (out_free) begin
            out_valid_d = 1'b1;
            out_id_d    = '0;
            out_st_d    = ST_FULL;
            state_d     = S_IDLE;
          end
        end else begin
          // Advance the token one cell, wrapping at the top slot.
          ctrl.advance = 1'b1;
          probe_d      = (probe_q == IDX_W'(SLOTS - 1)) ? '0 : probe_q + IDX_W'(1);
          steps_d      = steps_q + IDX_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= '0;
      probe_q     <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      probe_q     <= probe_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the result register needs no reset.
  always_ff @(posedge clk_i) begin
    out_id_q <= out_id_d;
    out_st_q <= out_st_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.granted_id = out_id_q;
  assign rsp_o.status     = out_st_q;

endmodule

// ===== tb/nfa_checker.sv =====
// Checker of the next-fit identifier allocator: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module nfa_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nfa_cmd_if   cmd_mon,
  nfa_rsp_if   rsp_mon,
  output int   mismatches_o,
  output int   outstanding_o,
  output int   checked_o,
  output int   grants_o,
  output int   full_o,
  output int   range_o,
  output int   unalloc_o
);
  import nfa_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic [ST_W-1:0] status;
  } answer_t;

  // Shadow of the used-bit map and the last granted slot.
  logic [SLOTS-1:0] slot_taken;
  logic [IDX_W-1:0] last_grant;
  answer_t          pending_answers[$];

  // Apply one request to the shadow map and return the answer it earns.
  function automatic answer_t next_fit_answer(logic command, logic [ID_W-1:0] rid);
    answer_t          ans;
    logic [IDX_W-1:0] probe;
    logic             found;
    ans.granted_id = '0;
    ans.status     = ST_OK;
    if (command == CMD_ALLOC) begin
      probe = last_grant;
      found = 1'b0;
      for (int n = 0; n < SLOTS; n++) begin
        if (!found && !slot_taken[probe]) begin
          found             = 1'b1;
          slot_taken[probe] = 1'b1;
          last_grant        = probe;
          ans.granted_id    = ID_W'(probe) + ID_W'(1);
        end
        probe = (probe == IDX_W'(SLOTS - 1)) ? '0 : probe + IDX_W'(1);
      end
      if (!found) ans.status = ST_FULL;
    end else if (rid == '0 || rid > ID_W'(SLOTS)) begin
      ans.status = ST_RANGE;
    end else if (!slot_taken[IDX_W'(rid - ID_W'(1))]) begin
      ans.status = ST_FREE;
    end else begin
      slot_taken[IDX_W'(rid - ID_W'(1))] = 1'b0;
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    if (!rst_ni) begin
      slot_taken = '0;
      last_grant = '0;
      pending_answers.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
      checked_o     = 0;
      grants_o      = 0;
      full_o        = 0;
      range_o       = 0;
      unalloc_o     = 0;
    end else begin
      // Retire the response beat first: it always belongs to an earlier request.
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_answers.size() == 0) begin
          $error("response beat with no request waiting: granted_id %0d status %0d",
                 rsp_mon.granted_id, rsp_mon.status);
          mismatches_o++;
        end else begin
          want = pending_answers.pop_front();
          checked_o++;
          if (rsp_mon.granted_id !== want.granted_id) begin
            $error("granted_id: expected %0d, actual %0d", want.granted_id,
                   rsp_mon.granted_id);
            mismatches_o++;
          end
          if (rsp_mon.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
            mismatches_o++;
          end
          case (want.status)
            ST_OK:    if (want.granted_id != '0) grants_o++;
            ST_FULL:  full_o++;
            ST_RANGE: range_o++;
            default:  unalloc_o++;
          endcase
        end
      end
      if (cmd_mon.valid && cmd_mon.ready)
        pending_answers.push_back(next_fit_answer(cmd_mon.command, cmd_mon.release_id));
      outstanding_o = pending_answers.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// Top of the allocator testbench: clock, reset, request and response drivers, verdict.
`timescale 1ns / 1ps

module tb;
  import nfa_pkg::*;

  logic clk_i;
  logic rst_ni;

  nfa_cmd_if cmd_ch ();
  nfa_rsp_if rsp_ch ();

  int mismatches;
  int outstanding;
  int checked;
  int grants;
  int fulls;
  int ranges;
  int unallocs;

  // Idle odds in percent for each side, changed between phases.
  int send_idle_pct;
  int recv_idle_pct;
  // Cycles the receiver still has to hold off; counted down by the receiver itself.
  int recv_hold;

  next_fit_id_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .rsp_o  (rsp_ch)
  );

  nfa_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_mon       (cmd_ch),
    .rsp_mon       (rsp_ch),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .grants_o      (grants),
    .full_o        (fulls),
    .range_o       (ranges),
    .unalloc_o     (unallocs)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Response side: decide ready at each falling edge. A pending hold-off wins over
  // the random odds, so a long stall backs the block up into its request side.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        recv_hold--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request beat, optionally after a random gap, and hold it until
  // the block takes it. Enter and leave at a falling edge; valid stays high on
  // exit so back-to-back beats need no second assignment in the same step.
  task automatic send_beat(input logic command, input logic [ID_W-1:0] rid);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= command;
    cmd_ch.release_id <= rid;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random traffic. alloc_pct steers occupancy: a high share fills the map
  // and runs into the full case, a low share drains it. Most releases name an
  // identifier in range (hit or miss depends on occupancy); the rest are noise
  // outside the range. The release field of an allocate carries random bits.
  task automatic run_mix(input int beats, input int alloc_pct);
    int              roll;
    logic [ID_W-1:0] noise_id;
    for (int i = 0; i < beats; i++) begin
      roll = $urandom_range(99);
      noise_id = ($urandom_range(1) == 0) ? '0
                 : ID_W'($urandom_range((1 << ID_W) - 1, SLOTS + 1));
      if (roll < alloc_pct)
        send_beat(CMD_ALLOC, ID_W'($urandom));
      else if (roll < 92)
        send_beat(CMD_RELEASE, ID_W'($urandom_range(SLOTS, 1)));
      else
        send_beat(CMD_RELEASE, noise_id);
    end
  endtask

  // Pause the request side until every answer is back.
  task automatic drain_answers();
    cmd_ch.valid <= 1'b0;
    @(negedge clk_i);
    wait (outstanding == 0);
    @(negedge clk_i);
  endtask

  initial begin
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_ALLOC;
    cmd_ch.release_id = '0;
    rst_ni            = 1'b0;
    send_idle_pct     = 12;
    recv_idle_pct     = 52;
    recv_hold         = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reject bad releases on an empty map first.
    send_beat(CMD_RELEASE, '0);                    // identifier zero
    send_beat(CMD_RELEASE, ID_W'(SLOTS + 1));      // just above the range
    send_beat(CMD_RELEASE, '1);                    // every field bit high
    send_beat(CMD_RELEASE, ID_W'(1));              // lowest id, not allocated
    send_beat(CMD_RELEASE, ID_W'(SLOTS));          // highest id, not allocated
    // Allocate a few; the release field is ignored, so load it with assorted values.
    send_beat(CMD_ALLOC, '1);
    send_beat(CMD_ALLOC, '0);
    send_beat(CMD_ALLOC, ID_W'(SLOTS));
    // Free the last grant and allocate again: the same slot comes back.
    send_beat(CMD_RELEASE, ID_W'(3));
    send_beat(CMD_ALLOC, '0);
    // Free an older slot, then a double release of it.
    send_beat(CMD_RELEASE, ID_W'(1));
    send_beat(CMD_RELEASE, ID_W'(1));
    send_beat(CMD_ALLOC, '0);
    send_beat(CMD_ALLOC, '0);
    send_beat(CMD_RELEASE, ID_W'(2));
    send_beat(CMD_RELEASE, ID_W'(SLOTS));
    drain_answers();

    // Fill the whole map and go past full. Hold the receiver off for a long
    // stretch at the start so the block fills up and stalls its request side.
    recv_hold = 150;
    for (int i = 0; i < SLOTS + 2; i++)
      send_beat(CMD_ALLOC, ID_W'($urandom));
    // Release the top slot and scan up to it, then release the lowest and wrap the scan around to it.
    send_beat(CMD_RELEASE, ID_W'(SLOTS));
    send_beat(CMD_ALLOC, '0);
    send_beat(CMD_ALLOC, '0);
    send_beat(CMD_RELEASE, ID_W'(1));
    send_beat(CMD_ALLOC, '0);
    drain_answers();

    // Phase one: light sender gaps, heavy receiver stalls.
    run_mix(85, 75);
    run_mix(85, 25);
    drain_answers();

    // Phase two: the other way round.
    send_idle_pct = 52;
    recv_idle_pct = 12;
    run_mix(85, 75);
    run_mix(85, 25);
    drain_answers();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_mix(85, 75);
    run_mix(85, 25);

    // Let the last answers come back, then allow a full scan lap of slack
    // for any stray beat.
    cmd_ch.valid <= 1'b0;
    wait (outstanding == 0);
    repeat (SLOTS + 8) @(posedge clk_i);

    $display("Run covered %0d answers: %0d grants, %0d full,", checked, grants, fulls);
    $display("%0d out of range, %0d not allocated, under three idle mixes and a long stall.",
             ranges, unallocs);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/nfa_pkg.sv
hdl/nfa_cmd_if.sv
hdl/nfa_rsp_if.sv
hdl/nfa_cell.sv
hdl/next_fit_id_allocator.sv
tb/nfa_checker.sv
tb/tb.sv
